// File: rtl/crf_pkg.sv
// ---------------------------------------------------------------------------
// crf_pkg
// Shared types, constants and helpers for the cascaded resonant filter:
// request structs, register and mode codes, sequencer and lane op codes.
// ---------------------------------------------------------------------------
package crf_pkg;

	localparam int DEF_MAX_STAGES = 8;
	localparam int DEF_CHANNELS = 2;
	localparam int IO_CH = 2;
	localparam int MIN_STAGES = 2;

	localparam int SMP_W = 16;
	localparam int CFG_W = 17;
	localparam int FB_W = 30;

	localparam logic [CFG_W-1:0] ONE_Q16 = 17'd65536;
	localparam logic [CFG_W-1:0] CUT_LIMIT = 17'd65529;

	typedef enum logic [1:0] {
		CFG_MODE = 2'd0,
		CFG_CUTOFF = 2'd1,
		CFG_RESONANCE = 2'd2,
		CFG_STAGES = 2'd3
	} cfg_reg_t;

	typedef enum logic [1:0] {
		MODE_LP = 2'd0,
		MODE_HP = 2'd1,
		MODE_BP = 2'd2
	} mode_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_LOAD0,
		ST_FBLO,
		ST_FBHI,
		ST_FBACC,
		ST_SUM,
		ST_GLO,
		ST_GHI,
		ST_GACC,
		ST_UPD0,
		ST_LOADK,
		ST_MULK,
		ST_UPDK,
		ST_DONE
	} fsm_t;

	typedef enum logic [3:0] {
		LOP_IDLE,
		LOP_LOAD0,
		LOP_FBLO,
		LOP_FBHI,
		LOP_SUM,
		LOP_GLO,
		LOP_GHI,
		LOP_UPD0,
		LOP_LOADK,
		LOP_MULK,
		LOP_UPDK
	} lane_op_t;

	typedef struct packed {
		lane_op_t op;
		logic clr;
	} lane_ctl_t;

	typedef struct packed {
		logic signed [SMP_W-1:0] sample_left;
		logic signed [SMP_W-1:0] sample_right;
		logic [1:0] channels_present;
	} frame_t;

	typedef struct packed {
		logic signed [SMP_W-1:0] filtered_left;
		logic signed [SMP_W-1:0] filtered_right;
		logic [1:0] channels_out;
	} result_t;

	function automatic logic signed [31:0] sat32(input logic signed [52:0] v);
		logic signed [31:0] r;
		if (v[52:31] == {22{v[52]}})
			r = v[31:0];
		else if (v[52])
			r = {1'b1, 31'd0};
		else
			r = {1'b0, {31{1'b1}}};
		return r;
	endfunction

endpackage

// File: rtl/crf_div.sv
// ---------------------------------------------------------------------------
// crf_div
// Resonance feedback coefficient: fb = r + floor(r * 2^16 / (1 - min(g, limit))),
// restoring division, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module crf_div (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic [crf_pkg::CFG_W-1:0]       gain,
	input  logic [crf_pkg::CFG_W-1:0]       resonance,
	output logic                            busy,
	output logic [crf_pkg::FB_W-1:0]        fb
);

	localparam int NUM_W = crf_pkg::CFG_W + 16;
	localparam int CNT_W = $clog2(NUM_W + 1);

	logic                        run_q;
	logic [CNT_W-1:0]            cnt_q;
	logic [crf_pkg::CFG_W-1:0]   rem_q;
	logic [NUM_W-1:0]            quo_q;
	logic [crf_pkg::CFG_W-1:0]   den_q;
	logic [crf_pkg::CFG_W-1:0]   r_q;
	logic [crf_pkg::FB_W-1:0]    fb_q;

	logic [crf_pkg::CFG_W-1:0]   gl;
	logic [crf_pkg::CFG_W-1:0]   den;
	logic [crf_pkg::CFG_W:0]     rem_sh;
	logic [crf_pkg::CFG_W:0]     rem_nx;
	logic                        ge;
	logic [crf_pkg::FB_W-1:0]    fb_sum;

	always_comb begin
		gl = (gain > crf_pkg::CUT_LIMIT) ? crf_pkg::CUT_LIMIT : gain;
		den = crf_pkg::ONE_Q16 - gl;
		rem_sh = {rem_q, quo_q[NUM_W-1]};
		ge = rem_sh >= {1'b0, den_q};
		rem_nx = ge ? (rem_sh - {1'b0, den_q}) : rem_sh;
		fb_sum = {{(crf_pkg::FB_W - crf_pkg::CFG_W){1'b0}}, r_q} + quo_q[crf_pkg::FB_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			cnt_q <= '0;
			fb_q <= '0;
		end else if (start) begin
			run_q <= 1'b1;
			cnt_q <= '0;
		end else if (run_q) begin
			if (cnt_q == CNT_W'(NUM_W)) begin
				run_q <= 1'b0;
				fb_q <= fb_sum;
			end else begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= {resonance, 16'd0};
			den_q <= den;
			r_q <= resonance;
		end else if (run_q && (cnt_q != CNT_W'(NUM_W))) begin
			rem_q <= rem_nx[crf_pkg::CFG_W-1:0];
			quo_q <= {quo_q[NUM_W-2:0], ge};
		end
	end

	assign busy = run_q;
	assign fb = fb_q;

endmodule

// File: rtl/crf_lane.sv
// ---------------------------------------------------------------------------
// crf_lane
// One channel of the cascade: stage storage, a shared 34x18 multiplier with
// a product register and an accumulator, stepped by the sequencer's ops.
// ---------------------------------------------------------------------------
module crf_lane #(
	parameter int MAX_STAGES = crf_pkg::DEF_MAX_STAGES,
	localparam int SIDX_W = $clog2(MAX_STAGES),
	localparam int CNT_W = $clog2(MAX_STAGES + 1)
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  crf_pkg::lane_ctl_t             ctl,
	input  logic [SIDX_W-1:0]              sidx,
	input  logic [CNT_W-1:0]               clr_from,
	input  logic                           active,
	input  logic [crf_pkg::CFG_W-1:0]      g,
	input  logic [crf_pkg::FB_W-1:0]       fb,
	input  logic signed [17:0]             x,
	output logic signed [31:0]             first,
	output logic signed [31:0]             last
);

	logic signed [31:0] mem_q [MAX_STAGES];
	logic signed [31:0] rd;
	logic signed [31:0] base_q;
	logic signed [31:0] prev_q;
	logic signed [31:0] first_q;
	logic signed [31:0] last_q;
	logic signed [32:0] d_q;
	logic signed [48:0] sum_q;
	logic signed [51:0] prod_s1;
	logic [1:0]         sh_s1;
	logic               acc_en_s1;
	logic signed [67:0] acc_q;

	logic signed [33:0] mul_a;
	logic signed [17:0] mul_b;
	logic [1:0]         sh_nx;
	logic               acc_en_nx;
	logic signed [67:0] acc_ext;
	logic signed [67:0] acc_sh;
	logic signed [67:0] acc_shr;
	logic [52:0]        sum_w;
	logic [52:0]        upd0_w;
	logic [52:0]        updk_w;
	logic signed [31:0] new0;
	logic signed [31:0] newk;

	assign rd = mem_q[sidx];

	// multiplier operand select
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		sh_nx = 2'd0;
		acc_en_nx = 1'b0;
		case (ctl.op)
			crf_pkg::LOP_FBLO: begin
				mul_a = {d_q[32], d_q};
				mul_b = {2'b00, fb[15:0]};
				acc_en_nx = 1'b1;
			end
			crf_pkg::LOP_FBHI: begin
				mul_a = {d_q[32], d_q};
				mul_b = {{(34 - crf_pkg::FB_W){1'b0}}, fb[crf_pkg::FB_W-1:16]};
				sh_nx = 2'd1;
				acc_en_nx = 1'b1;
			end
			crf_pkg::LOP_GLO: begin
				mul_a = {2'b00, sum_q[31:0]};
				mul_b = {1'b0, g};
				acc_en_nx = 1'b1;
			end
			crf_pkg::LOP_GHI: begin
				mul_a = {{17{sum_q[48]}}, sum_q[48:32]};
				mul_b = {1'b0, g};
				sh_nx = 2'd2;
				acc_en_nx = 1'b1;
			end
			crf_pkg::LOP_MULK: begin
				mul_a = {d_q[32], d_q};
				mul_b = {1'b0, g};
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		acc_ext = {{16{prod_s1[51]}}, prod_s1};
		acc_sh = acc_ext <<< {sh_s1, 4'b0000};
		acc_shr = acc_q >>> 16;
		sum_w = {{35{x[17]}}, x} - {{21{base_q[31]}}, base_q} + acc_shr[52:0];
		upd0_w = {{21{base_q[31]}}, base_q} + acc_shr[52:0];
		updk_w = {{21{base_q[31]}}, base_q} + {{17{prod_s1[51]}}, prod_s1[51:16]};
		new0 = crf_pkg::sat32(upd0_w);
		newk = crf_pkg::sat32(updk_w);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_en_s1 <= 1'b0;
			for (int i = 0; i < MAX_STAGES; i++)
				mem_q[i] <= '0;
		end else begin
			acc_en_s1 <= acc_en_nx;
			if (ctl.clr) begin
				for (int i = 0; i < MAX_STAGES; i++)
					if (CNT_W'(i) >= clr_from)
						mem_q[i] <= '0;
			end else if (active && (ctl.op == crf_pkg::LOP_UPD0)) begin
				mem_q[0] <= new0;
			end else if (active && (ctl.op == crf_pkg::LOP_UPDK)) begin
				mem_q[sidx] <= newk;
			end
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= mul_a * mul_b;
		sh_s1 <= sh_nx;
		if ((ctl.op == crf_pkg::LOP_LOAD0) || (ctl.op == crf_pkg::LOP_SUM))
			acc_q <= '0;
		else if (acc_en_s1)
			acc_q <= acc_q + acc_sh;
		case (ctl.op)
			crf_pkg::LOP_LOAD0: begin
				base_q <= mem_q[0];
				d_q <= {mem_q[0][31], mem_q[0]} - {mem_q[1][31], mem_q[1]};
			end
			crf_pkg::LOP_SUM: begin
				sum_q <= sum_w[48:0];
			end
			crf_pkg::LOP_UPD0: begin
				prev_q <= new0;
				first_q <= new0;
			end
			crf_pkg::LOP_LOADK: begin
				base_q <= rd;
				d_q <= {prev_q[31], prev_q} - {rd[31], rd};
			end
			crf_pkg::LOP_UPDK: begin
				prev_q <= newk;
				last_q <= newk;
			end
			default: begin
			end
		endcase
	end

	assign first = first_q;
	assign last = last_q;

endmodule

// File: rtl/crf_merge.sv
// ---------------------------------------------------------------------------
// crf_merge
// Combines the lanes' first and last stages per filter mode, scales to Q1.15
// with saturation, and holds the result request in an output register.
// ---------------------------------------------------------------------------
module crf_merge (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  take,
	input  logic [1:0]                            mode,
	input  logic [1:0]                            present,
	input  logic [crf_pkg::IO_CH-1:0]             active,
	input  logic [crf_pkg::IO_CH-1:0][31:0]       first,
	input  logic [crf_pkg::IO_CH-1:0][31:0]       last,
	input  logic [crf_pkg::IO_CH-1:0][17:0]       x,
	input  logic                                  result_stall,
	output logic                                  result_valid,
	output crf_pkg::result_t                      result,
	output logic                                  free
);

	logic                         valid_q;
	crf_pkg::result_t             result_q;
	logic [33:0]                  o_w [crf_pkg::IO_CH];
	logic [33:0]                  h_w [crf_pkg::IO_CH];
	logic [15:0]                  s_w [crf_pkg::IO_CH];

	always_comb begin
		for (int i = 0; i < crf_pkg::IO_CH; i++) begin
			case (mode)
				crf_pkg::MODE_HP:
					o_w[i] = {{16{x[i][17]}}, x[i]} - {{2{last[i][31]}}, last[i]};
				crf_pkg::MODE_BP:
					o_w[i] = {{2{first[i][31]}}, first[i]} - {{2{last[i][31]}}, last[i]};
				default:
					o_w[i] = {{2{last[i][31]}}, last[i]};
			endcase
			h_w[i] = {o_w[i][33], o_w[i][33:1]};
			if (!active[i])
				s_w[i] = '0;
			else if (h_w[i][33:15] == {19{h_w[i][33]}})
				s_w[i] = h_w[i][15:0];
			else if (h_w[i][33])
				s_w[i] = 16'h8000;
			else
				s_w[i] = 16'h7fff;
		end
	end

	assign free = !valid_q || !result_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q <= 1'b0;
		else if (take)
			valid_q <= 1'b1;
		else if (!result_stall)
			valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (take) begin
			result_q.filtered_left <= s_w[0];
			result_q.filtered_right <= s_w[1];
			result_q.channels_out <= present;
		end
	end

	assign result_valid = valid_q;
	assign result = result_q;

endmodule

// File: rtl/cascaded_resonant_filter.sv
// ---------------------------------------------------------------------------
// cascaded_resonant_filter
// Each lane walks its stages on one multiplier: the resonant first stage steps through
// LOAD0, FBLO, FBHI, FBACC, SUM, GLO, GHI, GACC and UPD0, each further stage through
// LOADK, MULK and UPDK; a new frame is taken only once the last is in the result register.
// A cutoff or resonance write holds off frames while the feedback divider runs.
// Reset clears control, zeroes all stage state, registers return to defaults.
// ---------------------------------------------------------------------------
module cascaded_resonant_filter #(
	parameter int MAX_STAGES = crf_pkg::DEF_MAX_STAGES,
	parameter int CHANNELS = crf_pkg::DEF_CHANNELS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          frame_valid,
	output logic                          frame_stall,
	input  crf_pkg::frame_t               frame,
	output logic                          result_valid,
	input  logic                          result_stall,
	output crf_pkg::result_t              result,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [1:0]                    cfg_index,
	input  logic [crf_pkg::CFG_W-1:0]     cfg_data
);

	localparam int SIDX_W = $clog2(MAX_STAGES);
	localparam int CNT_W = $clog2(MAX_STAGES + 1);
	localparam int LANES = (CHANNELS < crf_pkg::IO_CH) ? CHANNELS : crf_pkg::IO_CH;

	crf_pkg::fsm_t              state_q;
	crf_pkg::fsm_t              state_nx;
	logic [1:0]                 mode_q;
	logic [crf_pkg::CFG_W-1:0]  gain_q;
	logic [crf_pkg::CFG_W-1:0]  res_q;
	logic [CNT_W-1:0]           ns_q;
	logic [SIDX_W-1:0]          k_q;
	logic                       start_q;
	crf_pkg::frame_t            item_q;

	logic                       cfg_we;
	logic                       frame_acc;
	logic [CNT_W-1:0]           ns_new;
	logic [crf_pkg::CFG_W-1:0]  g_eff;
	logic [crf_pkg::CFG_W-1:0]  r_eff;
	logic                       div_busy;
	logic [crf_pkg::FB_W-1:0]   fb;
	logic                       last_stage;
	logic                       merge_free;
	logic                       take;
	crf_pkg::lane_ctl_t         ctl;
	logic [1:0]                 nch;

	logic [crf_pkg::IO_CH-1:0][31:0] first_w;
	logic [crf_pkg::IO_CH-1:0][31:0] last_w;
	logic [crf_pkg::IO_CH-1:0][17:0] x_w;
	logic [crf_pkg::IO_CH-1:0]       act_w;

	assign cfg_ready = (state_q == crf_pkg::ST_IDLE);
	assign cfg_we = cfg_valid && cfg_ready;
	assign frame_stall = (state_q != crf_pkg::ST_IDLE) || div_busy || start_q || cfg_valid;
	assign frame_acc = frame_valid && !frame_stall;

	always_comb begin
		if (cfg_data[3:0] < 4'(crf_pkg::MIN_STAGES))
			ns_new = CNT_W'(crf_pkg::MIN_STAGES);
		else if ({1'b0, cfg_data[3:0]} > 5'(MAX_STAGES))
			ns_new = CNT_W'(MAX_STAGES);
		else
			ns_new = CNT_W'(cfg_data[3:0]);
	end

	assign g_eff = (gain_q > crf_pkg::ONE_Q16) ? crf_pkg::ONE_Q16 : gain_q;
	assign r_eff = (res_q > crf_pkg::ONE_Q16) ? crf_pkg::ONE_Q16 : res_q;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= crf_pkg::MODE_LP;
			gain_q <= crf_pkg::ONE_Q16;
			res_q <= '0;
			ns_q <= CNT_W'(crf_pkg::MIN_STAGES);
			start_q <= 1'b0;
		end else begin
			start_q <= cfg_we && ((cfg_index == crf_pkg::CFG_CUTOFF) ||
				(cfg_index == crf_pkg::CFG_RESONANCE));
			if (cfg_we) begin
				case (cfg_index)
					crf_pkg::CFG_MODE: mode_q <= cfg_data[1:0];
					crf_pkg::CFG_CUTOFF: gain_q <= cfg_data;
					crf_pkg::CFG_RESONANCE: res_q <= cfg_data;
					crf_pkg::CFG_STAGES: ns_q <= ns_new;
					default: begin
					end
				endcase
			end
		end
	end

	crf_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start_q),
		.gain      (g_eff),
		.resonance (r_eff),
		.busy      (div_busy),
		.fb        (fb)
	);

	assign last_stage = (CNT_W'(k_q) + CNT_W'(1)) == ns_q;

	always_comb begin
		state_nx = state_q;
		case (state_q)
			crf_pkg::ST_IDLE:  if (frame_acc) state_nx = crf_pkg::ST_LOAD0;
			crf_pkg::ST_LOAD0: state_nx = crf_pkg::ST_FBLO;
			crf_pkg::ST_FBLO:  state_nx = crf_pkg::ST_FBHI;
			crf_pkg::ST_FBHI:  state_nx = crf_pkg::ST_FBACC;
			crf_pkg::ST_FBACC: state_nx = crf_pkg::ST_SUM;
			crf_pkg::ST_SUM:   state_nx = crf_pkg::ST_GLO;
			crf_pkg::ST_GLO:   state_nx = crf_pkg::ST_GHI;
			crf_pkg::ST_GHI:   state_nx = crf_pkg::ST_GACC;
			crf_pkg::ST_GACC:  state_nx = crf_pkg::ST_UPD0;
			crf_pkg::ST_UPD0:  state_nx = crf_pkg::ST_LOADK;
			crf_pkg::ST_LOADK: state_nx = crf_pkg::ST_MULK;
			crf_pkg::ST_MULK:  state_nx = crf_pkg::ST_UPDK;
			crf_pkg::ST_UPDK:  state_nx = last_stage ? crf_pkg::ST_DONE : crf_pkg::ST_LOADK;
			crf_pkg::ST_DONE:  if (merge_free) state_nx = crf_pkg::ST_IDLE;
			default:           state_nx = crf_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		ctl.op = crf_pkg::LOP_IDLE;
		ctl.clr = cfg_we && (cfg_index == crf_pkg::CFG_STAGES);
		take = 1'b0;
		case (state_q)
			crf_pkg::ST_LOAD0: ctl.op = crf_pkg::LOP_LOAD0;
			crf_pkg::ST_FBLO:  ctl.op = crf_pkg::LOP_FBLO;
			crf_pkg::ST_FBHI:  ctl.op = crf_pkg::LOP_FBHI;
			crf_pkg::ST_SUM:   ctl.op = crf_pkg::LOP_SUM;
			crf_pkg::ST_GLO:   ctl.op = crf_pkg::LOP_GLO;
			crf_pkg::ST_GHI:   ctl.op = crf_pkg::LOP_GHI;
			crf_pkg::ST_UPD0:  ctl.op = crf_pkg::LOP_UPD0;
			crf_pkg::ST_LOADK: ctl.op = crf_pkg::LOP_LOADK;
			crf_pkg::ST_MULK:  ctl.op = crf_pkg::LOP_MULK;
			crf_pkg::ST_UPDK:  ctl.op = crf_pkg::LOP_UPDK;
			crf_pkg::ST_DONE:  take = merge_free;
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= crf_pkg::ST_IDLE;
			k_q <= '0;
		end else begin
			state_q <= state_nx;
			if (state_q == crf_pkg::ST_UPD0)
				k_q <= SIDX_W'(1);
			else if (state_q == crf_pkg::ST_UPDK)
				k_q <= k_q + SIDX_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (frame_acc)
			item_q <= frame;
	end

	assign nch = (item_q.channels_present > 2'(crf_pkg::IO_CH)) ?
		2'(crf_pkg::IO_CH) : item_q.channels_present;
	assign x_w[0] = {item_q.sample_left[crf_pkg::SMP_W-1], item_q.sample_left, 1'b0};
	assign x_w[1] = {item_q.sample_right[crf_pkg::SMP_W-1], item_q.sample_right, 1'b0};

	for (genvar ln = 0; ln < crf_pkg::IO_CH; ln++) begin : g_lane
		if (ln < LANES) begin : g_on
			assign act_w[ln] = 2'(ln) < nch;
			crf_lane #(
				.MAX_STAGES (MAX_STAGES)
			) u_lane (
				.clk      (clk),
				.arst_n   (arst_n),
				.ctl      (ctl),
				.sidx     (k_q),
				.clr_from (ns_new),
				.active   (act_w[ln]),
				.g        (g_eff),
				.fb       (fb),
				.x        (x_w[ln]),
				.first    (first_w[ln]),
				.last     (last_w[ln])
			);
		end else begin : g_off
			assign act_w[ln] = 1'b0;
			assign first_w[ln] = '0;
			assign last_w[ln] = '0;
		end
	end

	crf_merge u_merge (
		.clk          (clk),
		.arst_n       (arst_n),
		.take         (take),
		.mode         (mode_q),
		.present      (item_q.channels_present),
		.active       (act_w),
		.first        (first_w),
		.last         (last_w),
		.x            (x_w),
		.result_stall (result_stall),
		.result_valid (result_valid),
		.result       (result),
		.free         (merge_free)
	);

`ifndef SYNTHESIS
	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		frame_acc |=> (state_q == crf_pkg::ST_LOAD0))
		else $error("frame request did not start the stage walk");

	a_stage_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == crf_pkg::ST_UPDK) |-> ((CNT_W'(k_q) < ns_q) && (k_q != '0)))
		else $error("stage index outside the active cascade");

	a_fb_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != crf_pkg::ST_IDLE) |-> (!div_busy && !start_q))
		else $error("feedback coefficient changing during a frame");

	a_done_delivers: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == crf_pkg::ST_DONE) && take) |=> result_valid)
		else $error("finished frame not presented on the result channel");
`endif

endmodule

// File: test/tb.sv
// ---------------------------------------------------------------------------
// tb - cascaded resonant filter testbench
// Runs a short directed table (extremes, every mode, clamped registers, partial
// frames, stage count changes), then random frames under a series of register
// settings. Each result is checked against the table's value or an in-bench
// fixed-point model of the stage cascade, with random idling on both sides.
// ---------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NST = crf_pkg::DEF_MAX_STAGES;
	localparam int NCH = crf_pkg::DEF_CHANNELS;
	localparam int IOC = crf_pkg::IO_CH;
	localparam int CW = crf_pkg::CFG_W;
	localparam longint UNITY = crf_pkg::ONE_Q16;
	localparam longint GAIN_CAP = crf_pkg::CUT_LIMIT;
	localparam longint Q_MAX = 64'sh7fffffff;
	localparam longint Q_MIN = -64'sh80000000;
	localparam logic [1:0] MODE_THREE = 2'd3;

	typedef struct {
		logic is_reg;
		crf_pkg::cfg_reg_t reg_idx;
		int reg_val;
		crf_pkg::frame_t f;
		logic known;
		crf_pkg::result_t want;
	} plan_row_t;

	logic clk = 1'b0;
	logic arst_n;
	logic frame_valid;
	logic frame_stall;
	crf_pkg::frame_t frame;
	logic result_valid;
	logic result_stall;
	crf_pkg::result_t result;
	logic cfg_valid;
	logic cfg_ready;
	logic [1:0] cfg_index;
	logic [CW-1:0] cfg_data;

	logic signed [31:0] stage_q [NST*NCH];
	logic [1:0] mode_q;
	logic [CW-1:0] gain_q;
	logic [CW-1:0] reso_q;
	logic [3:0] stages_q;

	crf_pkg::result_t expected_out [$];
	plan_row_t plan [$];
	int idle_pct = 37;
	bit long_hold = 1'b0;
	int mismatches = 0;
	int results_seen = 0;
	int frames_sent = 0;
	int regs_written = 0;

	always #2 clk = ~clk;

	cascaded_resonant_filter dut (
		.clk(clk),
		.arst_n(arst_n),
		.frame_valid(frame_valid),
		.frame_stall(frame_stall),
		.frame(frame),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	function automatic int active_stage_count();
		int n;
		n = stages_q;
		if (n < crf_pkg::MIN_STAGES) n = crf_pkg::MIN_STAGES;
		if (n > NST) n = NST;
		return n;
	endfunction

	function automatic logic signed [31:0] clip32(longint v);
		if (v > Q_MAX) v = Q_MAX;
		else if (v < Q_MIN) v = Q_MIN;
		return v[31:0];
	endfunction

	function automatic logic signed [15:0] to_sample(longint q);
		longint v;
		v = q >>> 1;
		if (v > 32767) v = 32767;
		else if (v < -32768) v = -32768;
		return v[15:0];
	endfunction

	function automatic crf_pkg::result_t filter_frame(crf_pkg::frame_t f);
		crf_pkg::result_t y;
		longint x [IOC];
		logic signed [15:0] outs [IOC];
		longint g, r, gl, fb, s0, s1, sum, prev, cur, head, tail, o;
		int nch, ns;
		x[0] = longint'(f.sample_left) * 2;
		x[1] = longint'(f.sample_right) * 2;
		outs[0] = '0;
		outs[1] = '0;
		nch = f.channels_present;
		if (nch > IOC) nch = IOC;
		if (nch > NCH) nch = NCH;
		g = (gain_q > crf_pkg::ONE_Q16) ? UNITY : longint'(gain_q);
		r = (reso_q > crf_pkg::ONE_Q16) ? UNITY : longint'(reso_q);
		gl = (g > GAIN_CAP) ? GAIN_CAP : g;
		fb = r + (r * UNITY) / (UNITY - gl);
		ns = active_stage_count();
		for (int c = 0; c < nch; c++) begin
			s0 = stage_q[c];
			s1 = stage_q[NCH + c];
			sum = x[c] - s0 + ((fb * (s0 - s1)) >>> 16);
			stage_q[c] = clip32(s0 + ((g * sum) >>> 16));
			for (int s = 1; s < ns; s++) begin
				prev = stage_q[(s - 1) * NCH + c];
				cur = stage_q[s * NCH + c];
				stage_q[s * NCH + c] = clip32(cur + ((g * (prev - cur)) >>> 16));
			end
			head = stage_q[c];
			tail = stage_q[(ns - 1) * NCH + c];
			if (mode_q == crf_pkg::MODE_HP) o = x[c] - tail;
			else if (mode_q == crf_pkg::MODE_BP) o = head - tail;
			else o = tail;
			outs[c] = to_sample(o);
		end
		y.filtered_left = outs[0];
		y.filtered_right = outs[1];
		y.channels_out = f.channels_present;
		return y;
	endfunction

	function automatic plan_row_t on_reg(crf_pkg::cfg_reg_t idx, int val);
		plan_row_t row;
		row = '{is_reg: 1'b1, reg_idx: idx, reg_val: val, f: '0, known: 1'b0, want: '0};
		return row;
	endfunction

	function automatic plan_row_t on_frame(int l, int r, int n, logic known = 1'b0,
			int wl = 0, int wr = 0);
		plan_row_t row;
		row = '{is_reg: 1'b0, reg_idx: crf_pkg::CFG_MODE, reg_val: 0, f: '0,
			known: known, want: '0};
		row.f.sample_left = l[15:0];
		row.f.sample_right = r[15:0];
		row.f.channels_present = n[1:0];
		row.want.filtered_left = wl[15:0];
		row.want.filtered_right = wr[15:0];
		row.want.channels_out = n[1:0];
		return row;
	endfunction

	function automatic logic [15:0] pick_sample();
		case ($urandom_range(0, 9))
			0: return 16'h7fff;
			1: return 16'h8000;
			2, 3, 4: return 16'($urandom_range(0, 4095)) - 16'd2048;
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic crf_pkg::frame_t random_frame();
		crf_pkg::frame_t f;
		f.sample_left = pick_sample();
		f.sample_right = pick_sample();
		case ($urandom_range(0, 9))
			0: f.channels_present = 2'd0;
			1: f.channels_present = 2'd3;
			2, 3: f.channels_present = 2'd1;
			default: f.channels_present = 2'd2;
		endcase
		return f;
	endfunction

	function automatic int pick_coef(int typical_max);
		case ($urandom_range(0, 7))
			0: return 0;
			1: return 65536;
			2: return $urandom_range(65537, 131071);
			default: return $urandom_range(1, typical_max);
		endcase
	endfunction

	task automatic write_reg(crf_pkg::cfg_reg_t idx, int val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val[CW-1:0];
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		regs_written++;
		case (idx)
			crf_pkg::CFG_MODE: mode_q = val[1:0];
			crf_pkg::CFG_CUTOFF: gain_q = val[CW-1:0];
			crf_pkg::CFG_RESONANCE: reso_q = val[CW-1:0];
			crf_pkg::CFG_STAGES: begin
				stages_q = val[3:0];
				for (int s = active_stage_count(); s < NST; s++)
					for (int c = 0; c < NCH; c++)
						stage_q[s * NCH + c] = '0;
			end
			default: begin
			end
		endcase
	endtask

	task automatic send_frame(crf_pkg::frame_t f, logic known, crf_pkg::result_t want);
		crf_pkg::result_t got;
		int gap;
		frame <= f;
		frame_valid <= 1'b1;
		@(posedge clk);
		while (frame_stall) @(posedge clk);
		got = filter_frame(f);
		expected_out.push_back(known ? want : got);
		frames_sent++;
		if ($urandom_range(0, 99) < idle_pct) begin
			gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 40) : $urandom_range(1, 3);
			frame_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic drain();
		frame_valid <= 1'b0;
		wait (expected_out.size() == 0);
	endtask

	// result side: random stalls, plus one long hold so frame requests back up
	initial begin
		int i;
		result_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (long_hold) begin
				result_stall <= 1'b1;
				for (i = 0; i < 400; i++) @(posedge clk);
				long_hold = 1'b0;
			end
			result_stall <= ($urandom_range(0, 99) < idle_pct);
		end
	end

	always @(posedge clk) begin : check_results
		crf_pkg::result_t want;
		if (arst_n && result_valid && !result_stall) begin
			results_seen++;
			if (expected_out.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result %0d %0d %0d", result.filtered_left,
						result.filtered_right, result.channels_out);
			end else begin
				want = expected_out.pop_front();
				if (result.filtered_left !== want.filtered_left ||
						result.filtered_right !== want.filtered_right ||
						result.channels_out !== want.channels_out) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected %0d %0d %0d, got %0d %0d %0d",
							want.filtered_left, want.filtered_right, want.channels_out,
							result.filtered_left, result.filtered_right, result.channels_out);
				end
			end
		end
	end

	initial begin
		#4_000_000;
		$display("simulation failed");
		$finish;
	end

	initial begin
		frame_valid <= 1'b0;
		frame <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= crf_pkg::CFG_MODE;
		cfg_data <= '0;
		arst_n <= 1'b0;
		foreach (stage_q[i]) stage_q[i] = '0;
		mode_q = crf_pkg::MODE_LP;
		gain_q = crf_pkg::ONE_Q16;
		reso_q = '0;
		stages_q = 4'(crf_pkg::MIN_STAGES);

		// defaults: unity gain, no resonance, so low-pass passes the input through
		plan.push_back(on_frame(32767, -32768, 2, 1, 32767, -32768));
		plan.push_back(on_frame(-32768, 32767, 2, 1, -32768, 32767));
		plan.push_back(on_frame(0, 0, 2, 1, 0, 0));
		plan.push_back(on_frame(1234, 5678, 1, 1, 1234, 0));
		plan.push_back(on_frame(-1, 1, 0, 1, 0, 0));
		plan.push_back(on_frame(100, -100, 3, 1, 100, -100));
		plan.push_back(on_reg(crf_pkg::CFG_MODE, crf_pkg::MODE_HP));
		plan.push_back(on_frame(20000, -20000, 2, 1, 0, 0));
		plan.push_back(on_reg(crf_pkg::CFG_MODE, crf_pkg::MODE_BP));
		plan.push_back(on_frame(-7, 9, 2, 1, 0, 0));
		plan.push_back(on_reg(crf_pkg::CFG_MODE, MODE_THREE));
		plan.push_back(on_frame(-32768, 32767, 2, 1, -32768, 32767));
		plan.push_back(on_reg(crf_pkg::CFG_STAGES, NST));
		plan.push_back(on_frame(5000, -5000, 2, 1, 5000, -5000));
		plan.push_back(on_reg(crf_pkg::CFG_STAGES, 0));
		plan.push_back(on_frame(-5000, 5000, 2, 1, -5000, 5000));
		plan.push_back(on_reg(crf_pkg::CFG_STAGES, 15));
		plan.push_back(on_frame(321, -321, 2, 1, 321, -321));
		plan.push_back(on_reg(crf_pkg::CFG_MODE, crf_pkg::MODE_LP));
		plan.push_back(on_reg(crf_pkg::CFG_RESONANCE, 65536));
		plan.push_back(on_frame(16384, -16384, 2));
		plan.push_back(on_frame(-32768, 32767, 2));
		plan.push_back(on_frame(32767, -32768, 2));
		plan.push_back(on_reg(crf_pkg::CFG_RESONANCE, 131071));
		plan.push_back(on_frame(0, 0, 2));
		plan.push_back(on_reg(crf_pkg::CFG_STAGES, 1));
		plan.push_back(on_reg(crf_pkg::CFG_RESONANCE, 30000));
		plan.push_back(on_reg(crf_pkg::CFG_CUTOFF, 0));
		plan.push_back(on_frame(12345, -12345, 2));
		plan.push_back(on_reg(crf_pkg::CFG_CUTOFF, 131071));
		plan.push_back(on_frame(-12345, 12345, 1));
		plan.push_back(on_reg(crf_pkg::CFG_CUTOFF, 20000));
		plan.push_back(on_frame(32767, -32768, 2));
		plan.push_back(on_frame(32767, -32768, 2));
		plan.push_back(on_reg(crf_pkg::CFG_MODE, crf_pkg::MODE_BP));
		plan.push_back(on_frame(-32768, 32767, 2));
		plan.push_back(on_reg(crf_pkg::CFG_MODE, crf_pkg::MODE_HP));
		plan.push_back(on_frame(32767, -32768, 3));

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		foreach (plan[i]) begin
			if (plan[i].is_reg) begin
				drain();
				write_reg(plan[i].reg_idx, plan[i].reg_val);
			end else begin
				send_frame(plan[i].f, plan[i].known, plan[i].want);
			end
		end

		for (int phase = 0; phase < 12; phase++) begin
			drain();
			case (phase)
				0: begin
					write_reg(crf_pkg::CFG_STAGES, NST);
					write_reg(crf_pkg::CFG_CUTOFF, 65536);
					write_reg(crf_pkg::CFG_RESONANCE, 65536);
					write_reg(crf_pkg::CFG_MODE, crf_pkg::MODE_BP);
				end
				1: begin
					write_reg(crf_pkg::CFG_STAGES, crf_pkg::MIN_STAGES);
					write_reg(crf_pkg::CFG_CUTOFF, 1);
					write_reg(crf_pkg::CFG_RESONANCE, 0);
					write_reg(crf_pkg::CFG_MODE, crf_pkg::MODE_HP);
				end
				default: begin
					write_reg(crf_pkg::CFG_MODE, $urandom_range(0, 3));
					write_reg(crf_pkg::CFG_CUTOFF, pick_coef(65535));
					write_reg(crf_pkg::CFG_RESONANCE, pick_coef(24000));
					write_reg(crf_pkg::CFG_STAGES, $urandom_range(0, 15));
				end
			endcase
			idle_pct = (phase == 3) ? 0 : 37;
			if (phase == 5) long_hold = 1'b1;
			for (int k = 0; k < 104; k++) begin
				// sender pause until the pipeline is empty
				if (phase == 7 && k == 52) drain();
				send_frame(random_frame(), 1'b0, '0);
			end
		end

		drain();
		repeat (40) @(posedge clk);
		$display("checked %0d results from %0d frames across %0d register writes",
			results_seen, frames_sent, regs_written);
		$display("covered all modes, 2 to 8 stages, gain and resonance extremes, partial frames");
		if (mismatches == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

// File: sim.f
rtl/crf_pkg.sv
rtl/crf_div.sv
rtl/crf_lane.sv
rtl/crf_merge.sv
rtl/cascaded_resonant_filter.sv
test/tb.sv
